/* src/sfe_pkg.sv */
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types, micro-op codes and constants for the Schwefel fitness unit.
// ----------------------------------------------------------------------------
package sfe_pkg;

    localparam int GENE_W = 24;

    // Q30 constants
    localparam logic [30:0] HALF_PI_Q30    = 31'd1686629713;
    localparam logic [30:0] ONE_Q30        = 31'd1073741824;
    localparam logic [38:0] SCHWEFEL_K_Q30 = 39'd449879474008;

    // Term sum limits, 40-bit signed
    localparam logic signed [40:0] SUM_MAX = 41'sd549755813887;
    localparam logic signed [40:0] SUM_MIN = -41'sd549755813888;

    // Fitness limits, 31-bit signed
    localparam logic signed [63:0] FIT_MAX = 64'sd1073741823;
    localparam logic signed [63:0] FIT_MIN = -64'sd1073741824;

    // Index of the last polynomial divisor
    localparam logic [1:0] DIV_LAST = 2'd3;

    // Input request
    typedef struct packed {
        logic signed [GENE_W-1:0] gene_value;
        logic                     last_gene;
    } t_gene;

    // Output request
    typedef struct packed {
        logic signed [30:0] fitness;
        logic [6:0]         genes_counted;
        logic               range_flag;
    } t_result;

    // Datapath micro-ops
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQRT,
        OP_RED,
        OP_FOLD,
        OP_T2_MUL,
        OP_T2_SET,
        OP_DIV_MUL,
        OP_DIV_FIX,
        OP_P_MUL,
        OP_V_SET,
        OP_M_MUL,
        OP_M_SET,
        OP_TERM_MUL,
        OP_ACC,
        OP_BASE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] div_sel;
    } t_cmd;

    typedef struct packed {
        logic full;       // gene count already at its limit
        logic x_ge_half;  // angle still at or above pi/2
        logic out_busy;   // output register holds a stalled result
    } t_status;

    // Divisors of the sine series, innermost first
    function automatic logic [6:0] div_const(input logic [1:0] sel);
        logic [6:0] d;
        case (sel)
            2'd0:    d = 7'd72;
            2'd1:    d = 7'd42;
            2'd2:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); quotient is low by at most one
    function automatic logic [29:0] div_recip(input logic [1:0] sel);
        logic [29:0] m;
        case (sel)
            2'd0:    m = 30'd59652323;
            2'd1:    m = 30'd102261126;
            2'd2:    m = 30'd214748364;
            default: m = 30'd715827882;
        endcase
        return m;
    endfunction

endpackage

/* src/sfe_ctrl.sv */
// ----------------------------------------------------------------------------
// sfe_ctrl
// Sequencer: accepts genes, steps the datapath through root, reduction,
// sine series, accumulate and result.
// ----------------------------------------------------------------------------
module sfe_ctrl #(
    parameter int SQRT_STEPS = 19
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_gene_valid,
    input  logic             i_last_gene,
    output logic             o_gene_stall,
    input  sfe_pkg::t_status i_status,
    output sfe_pkg::t_cmd    o_cmd
);

    localparam int ITER_W = $clog2(SQRT_STEPS);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SQRT = 6'b000010,
        ST_RED  = 6'b000100,
        ST_POLY = 6'b001000,
        ST_BASE = 6'b010000,
        ST_EMIT = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    sfe_pkg::t_op     r_op, n_op;
    logic [1:0]       r_div, n_div;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic             r_last, n_last;

    // next state and command
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_div         = r_div;
        n_iter        = r_iter;
        n_last        = r_last;
        o_gene_stall  = 1'b1;
        o_cmd.op      = sfe_pkg::OP_NONE;
        o_cmd.div_sel = r_div;
        case (r_state)
            ST_IDLE: begin
                o_gene_stall = 1'b0;
                if (i_gene_valid) begin
                    o_cmd.op = sfe_pkg::OP_LOAD;
                    n_last   = i_last_gene;
                    n_iter   = '0;
                    if (i_status.full) begin
                        n_state = i_last_gene ? ST_BASE : ST_IDLE;
                    end else begin
                        n_state = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                o_cmd.op = sfe_pkg::OP_SQRT;
                if (r_iter == ITER_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_RED;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_RED: begin
                if (i_status.x_ge_half) begin
                    o_cmd.op = sfe_pkg::OP_RED;
                end else begin
                    o_cmd.op = sfe_pkg::OP_FOLD;
                    n_state  = ST_POLY;
                    n_op     = sfe_pkg::OP_T2_MUL;
                    n_div    = 2'd0;
                end
            end
            ST_POLY: begin
                o_cmd.op = r_op;
                case (r_op)
                    sfe_pkg::OP_T2_MUL:  n_op = sfe_pkg::OP_T2_SET;
                    sfe_pkg::OP_T2_SET:  n_op = sfe_pkg::OP_DIV_MUL;
                    sfe_pkg::OP_DIV_MUL: n_op = sfe_pkg::OP_DIV_FIX;
                    sfe_pkg::OP_DIV_FIX: begin
                        n_op = (r_div == sfe_pkg::DIV_LAST) ? sfe_pkg::OP_M_MUL
                                                            : sfe_pkg::OP_P_MUL;
                    end
                    sfe_pkg::OP_P_MUL:   n_op = sfe_pkg::OP_V_SET;
                    sfe_pkg::OP_V_SET: begin
                        n_div = r_div + 1'b1;
                        n_op  = sfe_pkg::OP_DIV_MUL;
                    end
                    sfe_pkg::OP_M_MUL:    n_op = sfe_pkg::OP_M_SET;
                    sfe_pkg::OP_M_SET:    n_op = sfe_pkg::OP_TERM_MUL;
                    sfe_pkg::OP_TERM_MUL: n_op = sfe_pkg::OP_ACC;
                    sfe_pkg::OP_ACC: begin
                        n_state = r_last ? ST_BASE : ST_IDLE;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_BASE: begin
                o_cmd.op = sfe_pkg::OP_BASE;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.op = sfe_pkg::OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= sfe_pkg::OP_NONE;
            r_div   <= 2'd0;
            r_iter  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_div   <= n_div;
            r_iter  <= n_iter;
            r_last  <= n_last;
        end
    end

endmodule

/* src/sfe_datapath.sv */
// ----------------------------------------------------------------------------
// sfe_datapath
// Clamp, bit-serial root, angle reduction, shared 32x32 multiplier for the
// sine series and term, saturating accumulator and output register.
// ----------------------------------------------------------------------------
module sfe_datapath #(
    parameter int MAX_GENES = 64,
    parameter int FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfe_pkg::t_cmd    i_cmd,
    input  sfe_pkg::t_gene   i_gene,
    output sfe_pkg::t_status o_status,
    input  logic             i_result_stall,
    output logic             o_result_valid,
    output sfe_pkg::t_result o_result
);

    localparam int A_W    = sfe_pkg::GENE_W;
    localparam int N_W    = A_W + FRAC_BITS;
    localparam int R_W    = (N_W + 1) / 2;
    localparam int SH     = 30 - FRAC_BITS;
    localparam int X_W    = R_W + SH;
    localparam int RM_W   = R_W + 4;
    localparam int CNT_W  = $clog2(MAX_GENES + 1);
    localparam int BASE_W = 39 + CNT_W;

    localparam logic signed [47:0] LIMIT = 48'sd500 <<< FRAC_BITS;
    localparam logic [BASE_W-1:0]  HALF  = BASE_W'(1) << (29 - FRAC_BITS);

    logic [A_W-1:0]     r_a;
    logic               r_gneg;
    logic [2*R_W-1:0]   r_n;
    logic [RM_W-1:0]    r_rem;
    logic [R_W-1:0]     r_root;
    logic [X_W-1:0]     r_x;
    logic [1:0]         r_q;
    logic               r_sneg;
    logic [30:0]        r_t;
    logic [31:0]        r_t2;
    logic [31:0]        r_v;
    logic [30:0]        r_p;
    logic [30:0]        r_m;
    logic [63:0]        r_prod;
    logic signed [39:0] r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [BASE_W-1:0]  r_base;
    logic [BASE_W-1:0]  r_bsh;
    logic               r_flag;
    logic               r_out_valid;
    sfe_pkg::t_result   r_out;

    // clamp and magnitude of the incoming gene
    logic signed [47:0] g_ext, g_cl;
    logic               g_clamp;
    logic [A_W-1:0]     g_abs;
    logic               full;

    always_comb begin
        g_ext   = 48'(i_gene.gene_value);
        g_clamp = 1'b0;
        g_cl    = g_ext;
        if (g_ext > LIMIT) begin
            g_cl    = LIMIT;
            g_clamp = 1'b1;
        end else if (g_ext < -LIMIT) begin
            g_cl    = -LIMIT;
            g_clamp = 1'b1;
        end
        g_abs = A_W'(g_cl[47] ? -g_cl : g_cl);
        full  = (r_cnt >= CNT_W'(MAX_GENES));
    end

    // one root bit per step
    logic [1:0]      top2;
    logic [RM_W-1:0] rem_sh;
    logic [RM_W:0]   trial;
    logic            root_ok;
    logic [R_W-1:0]  n_root;

    always_comb begin
        top2    = r_n[2*R_W-1 -: 2];
        rem_sh  = {r_rem[RM_W-3:0], top2};
        trial   = {1'b0, rem_sh} - (RM_W+1)'({r_root, 2'b01});
        root_ok = !trial[RM_W];
        n_root  = {r_root[R_W-2:0], root_ok};
    end

    // shared multiplier operands
    logic [31:0] mul_a, mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            sfe_pkg::OP_T2_MUL: begin
                mul_a = 32'(r_t);
                mul_b = 32'(r_t);
            end
            sfe_pkg::OP_DIV_MUL: begin
                mul_a = r_v;
                mul_b = 32'(sfe_pkg::div_recip(i_cmd.div_sel));
            end
            sfe_pkg::OP_P_MUL: begin
                mul_a = r_t2;
                mul_b = 32'(r_p);
            end
            sfe_pkg::OP_M_MUL: begin
                mul_a = 32'(r_t);
                mul_b = 32'(r_p);
            end
            sfe_pkg::OP_TERM_MUL: begin
                mul_a = 32'(r_a);
                mul_b = 32'(r_m);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // quotient correction for the constant divide
    logic [31:0] quo0, quo_rem, quo;
    logic [31:0] dconst;

    always_comb begin
        dconst  = 32'(sfe_pkg::div_const(i_cmd.div_sel));
        quo0    = r_prod[63:32];
        quo_rem = r_v - 32'(quo0 * dconst);
        quo     = quo0 + 32'(quo_rem >= dconst);
    end

    // rounded term and saturating sum
    logic [63:0]        term_rnd;
    logic signed [40:0] term, sum_w, sum_sat;

    always_comb begin
        term_rnd = r_prod + (64'd1 << 29);
        term     = $signed(41'(term_rnd[63:30]));
        if (r_gneg != r_sneg) begin
            term = -term;
        end
        sum_w = 41'(r_sum) + term;
        if (sum_w > sfe_pkg::SUM_MAX) begin
            sum_sat = sfe_pkg::SUM_MAX;
        end else if (sum_w < sfe_pkg::SUM_MIN) begin
            sum_sat = sfe_pkg::SUM_MIN;
        end else begin
            sum_sat = sum_w;
        end
    end

    // fitness with saturation
    logic signed [63:0] fit_w;
    logic signed [30:0] fit_sat;

    always_comb begin
        fit_w = $signed(64'(r_bsh)) - 64'(r_sum);
        if (fit_w > sfe_pkg::FIT_MAX) begin
            fit_sat = 31'(sfe_pkg::FIT_MAX);
        end else if (fit_w < sfe_pkg::FIT_MIN) begin
            fit_sat = 31'(sfe_pkg::FIT_MIN);
        end else begin
            fit_sat = 31'(fit_w);
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
        case (i_cmd.op)
            sfe_pkg::OP_LOAD: begin
                r_a    <= g_abs;
                r_gneg <= g_cl[47];
                r_n    <= (2*R_W)'(g_abs) << FRAC_BITS;
                r_rem  <= '0;
                r_root <= '0;
                r_q    <= 2'd0;
            end
            sfe_pkg::OP_SQRT: begin
                r_n    <= r_n << 2;
                r_rem  <= root_ok ? trial[RM_W-1:0] : rem_sh;
                r_root <= n_root;
                r_x    <= X_W'(n_root) << SH;
            end
            sfe_pkg::OP_RED: begin
                r_x <= r_x - X_W'(sfe_pkg::HALF_PI_Q30);
                r_q <= r_q + 1'b1;
            end
            sfe_pkg::OP_FOLD: begin
                r_t    <= r_q[0] ? (sfe_pkg::HALF_PI_Q30 - 31'(r_x)) : 31'(r_x);
                r_sneg <= r_q[1];
            end
            sfe_pkg::OP_T2_SET: begin
                r_t2 <= r_prod[61:30];
                r_v  <= r_prod[61:30];
            end
            sfe_pkg::OP_DIV_FIX: r_p <= sfe_pkg::ONE_Q30 - 31'(quo);
            sfe_pkg::OP_V_SET:   r_v <= r_prod[61:30];
            sfe_pkg::OP_M_SET:   r_m <= r_prod[60:30];
            sfe_pkg::OP_BASE:    r_bsh <= (r_base + HALF) >> SH;
            default: begin
            end
        endcase
    end

    // accumulator, count, flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_base      <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                sfe_pkg::OP_LOAD: begin
                    r_flag <= r_flag | g_clamp | full;
                    if (!full) begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_base <= r_base + BASE_W'(sfe_pkg::SCHWEFEL_K_Q30);
                    end
                end
                sfe_pkg::OP_ACC: r_sum <= 40'(sum_sat);
                sfe_pkg::OP_EMIT: begin
                    r_sum  <= '0;
                    r_cnt  <= '0;
                    r_base <= '0;
                    r_flag <= 1'b0;
                end
                default: begin
                end
            endcase
            if (i_cmd.op == sfe_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_result_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sfe_pkg::OP_EMIT) begin
            r_out.fitness       <= fit_sat;
            r_out.genes_counted <= 7'(r_cnt);
            r_out.range_flag    <= r_flag;
        end
    end

    assign o_status.full      = full;
    assign o_status.x_ge_half = (64'(r_x) >= 64'(sfe_pkg::HALF_PI_Q30));
    assign o_status.out_busy  = r_out_valid & i_result_stall;
    assign o_result_valid     = r_out_valid;
    assign o_result           = r_out;

endmodule

/* src/schwefel_fitness_eval.sv */
// A gene holds the input through 1 load, (24+FRAC_BITS+1)/2 = 19 root
//   steps, k reduction steps (k = floor(angle / (pi/2)), 0..14 at Q.14), 1 fold, 20 series steps.
// A gene past the count limit is not summed and takes only its load step.
// Throughput: one gene at a time; the root loop and the shared multiplier set it.
// A last gene then passes the base and emit states to form the result, plus any wait on the output.
// Reset (synchronous, active low) clears the sum, count, base, flag and output valid.
// ----------------------------------------------------------------------------
// schwefel_fitness_eval
// Schwefel fitness of one individual from a stream of fixed-point genes.
// ----------------------------------------------------------------------------
module schwefel_fitness_eval #(
    parameter int MAX_GENES = 64,
    parameter int FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_gene_valid,
    output logic             o_gene_stall,
    input  sfe_pkg::t_gene   i_gene,
    output logic             o_result_valid,
    input  logic             i_result_stall,
    output sfe_pkg::t_result o_result
);

    localparam int SQRT_STEPS = (sfe_pkg::GENE_W + FRAC_BITS + 1) / 2;

    sfe_pkg::t_cmd    cmd;
    sfe_pkg::t_status status;

    sfe_ctrl #(
        .SQRT_STEPS (SQRT_STEPS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gene_valid (i_gene_valid),
        .i_last_gene  (i_gene.last_gene),
        .o_gene_stall (o_gene_stall),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    sfe_datapath #(
        .MAX_GENES (MAX_GENES),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_gene         (i_gene),
        .o_status       (status),
        .i_result_stall (i_result_stall),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

`ifndef SYNTH
    // an accepted last gene keeps the input stalled while its result is formed
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_gene_valid && !o_gene_stall && i_gene.last_gene) |=> o_gene_stall)
        else $error("input not stalled after accepting a last gene");

    // a result is only loaded while the input side is stalled
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result_valid) |-> $past(o_gene_stall))
        else $error("result appeared without a gene in progress");

    // the output register is never overwritten while stalled
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && i_result_stall) |=> (o_result_valid && $stable(o_result)))
        else $error("stalled result changed or dropped");
`endif

endmodule
